>>> rtl/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg
// Shared constants and controller/datapath interface types for the
// finite-difference extrapolator.
// ----------------------------------------------------------------------------
`default_nettype none

package fde_pkg;

	localparam int unsigned MAX_LEN  = 32;
	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned DEPTH_W  = 6;

	typedef struct packed {
		logic collect;   // input word accepted
		logic start;     // accepted word closes the sequence
		logic rd;        // issue one row read
		logic row_end;   // row pass complete, advance to next row
		logic load;      // move result into output register
	} fde_cmd_t;

	typedef struct packed {
		logic last_rd;   // read address is last element of current row
		logic len_one;   // current row has one element
		logic all_zero;  // every difference written in this pass was zero
		logic out_free;  // output register can take a result
	} fde_sts_t;

endpackage

`default_nettype wire

>>> rtl/fde_ctrl.sv
// ----------------------------------------------------------------------------
// fde_ctrl
// Sequencer: collects words, then walks difference rows one element per
// cycle until a zero row or the single-element row, then posts the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              last,
	input  wire fde_pkg::fde_sts_t sts,
	output fde_pkg::fde_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.collect = in_valid && (state_q == ST_IDLE);
		cmd.start   = cmd.collect && last;
		cmd.rd      = (state_q == ST_READ);
		cmd.row_end = (state_q == ST_EVAL);
		cmd.load    = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && last)
						state_q <= ST_READ;
				end
				ST_READ: begin
					if (sts.last_rd)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (sts.len_one || sts.all_zero)
						state_q <= ST_FINISH;
					else
						state_q <= ST_READ;
				end
				ST_FINISH: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/fde_dp.sv
// ----------------------------------------------------------------------------
// fde_dp
// Datapath: row memory (differences computed in place), read pipeline,
// extrapolation accumulators, running totals and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_dp #(
	parameter int unsigned MAX_LEN = fde_pkg::MAX_LEN
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fde_pkg::fde_cmd_t                   cmd,
	output fde_pkg::fde_sts_t                        sts,
	input  wire logic signed [fde_pkg::SAMPLE_W-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [fde_pkg::DATA_W-1:0]        next_value,
	output logic signed [fde_pkg::DATA_W-1:0]        prev_value,
	output logic        [fde_pkg::DEPTH_W-1:0]       zero_depth,
	output logic                                     no_zero_row,
	output logic signed [fde_pkg::DATA_W-1:0]        total_next,
	output logic signed [fde_pkg::DATA_W-1:0]        total_prev
);

	localparam int unsigned AddrW = $clog2(MAX_LEN);
	localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
	localparam int unsigned DataW = fde_pkg::DATA_W;
	localparam int unsigned ExtW  = fde_pkg::DATA_W - fde_pkg::SAMPLE_W;

	logic [DataW-1:0] mem [MAX_LEN];

	logic [CntW-1:0]  cnt_q;
	logic [CntW-1:0]  len_q;
	logic [CntW-1:0]  len_m1;
	logic [CntW-1:0]  depth_q;
	logic [AddrW-1:0] rd_q;
	logic             cnt_full;

	logic             rd_vld_s1;
	logic [AddrW-1:0] idx_s1;
	logic [DataW-1:0] rdata_s1;

	logic [DataW-1:0] prev_q;
	logic [DataW-1:0] fwd_q;
	logic [DataW-1:0] bwd_q;
	logic             neg_q;
	logic             allz_q;
	logic             found_q;

	logic [DataW-1:0] diff;
	logic             elem_first;
	logic             elem_last;

	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [DataW-1:0] wr_data;

	logic [DataW-1:0] sum_next_q;
	logic [DataW-1:0] sum_prev_q;
	logic             out_valid_q;
	logic [DataW-1:0] next_q;
	logic [DataW-1:0] prev_out_q;
	logic [CntW-1:0]  depth_out_q;
	logic             nzr_q;

	assign cnt_full   = (cnt_q == CntW'(MAX_LEN));
	assign len_m1     = len_q - CntW'(1);
	assign diff       = rdata_s1 - prev_q;
	assign elem_first = (idx_s1 == '0);
	assign elem_last  = (CntW'(idx_s1) == len_m1);

	assign wr_en   = (cmd.collect && !cnt_full) || (rd_vld_s1 && !elem_first);
	assign wr_addr = cmd.collect ? cnt_q[AddrW-1:0] : (idx_s1 - AddrW'(1));
	assign wr_data = cmd.collect ? {{ExtW{sample[fde_pkg::SAMPLE_W-1]}}, sample} : diff;

	always_comb begin
		sts          = '0;
		sts.last_rd  = (CntW'(rd_q) == len_m1);
		sts.len_one  = (len_q == CntW'(1));
		sts.all_zero = allz_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	// row memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd)
			rdata_s1 <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			sum_next_q  <= '0;
			sum_prev_q  <= '0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cmd.start)
				cnt_q <= '0;
			else if (cmd.collect && !cnt_full)
				cnt_q <= cnt_q + CntW'(1);
			if (cmd.load) begin
				out_valid_q <= 1'b1;
				if (found_q) begin
					sum_next_q <= sum_next_q + fwd_q;
					sum_prev_q <= sum_prev_q + bwd_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.rd)
			idx_s1 <= rd_q;
		if (cmd.start) begin
			len_q   <= cnt_full ? cnt_q : (cnt_q + CntW'(1));
			depth_q <= '0;
			rd_q    <= '0;
			fwd_q   <= '0;
			bwd_q   <= '0;
			neg_q   <= 1'b0;
			allz_q  <= 1'b1;
		end else if (cmd.row_end) begin
			len_q   <= len_m1;
			depth_q <= depth_q + CntW'(1);
			rd_q    <= '0;
			neg_q   <= !neg_q;
			allz_q  <= 1'b1;
			found_q <= allz_q && !sts.len_one;
		end else begin
			if (cmd.rd)
				rd_q <= rd_q + AddrW'(1);
			if (rd_vld_s1) begin
				prev_q <= rdata_s1;
				if (elem_first)
					bwd_q <= neg_q ? (bwd_q - rdata_s1) : (bwd_q + rdata_s1);
				else if (diff != '0)
					allz_q <= 1'b0;
				if (elem_last)
					fwd_q <= fwd_q + rdata_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			next_q      <= found_q ? fwd_q : '0;
			prev_out_q  <= found_q ? bwd_q : '0;
			depth_out_q <= found_q ? depth_q : '0;
			nzr_q       <= !found_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_value  = next_q;
	assign prev_value  = prev_out_q;
	assign zero_depth  = fde_pkg::DEPTH_W'(depth_out_q);
	assign no_zero_row = nzr_q;
	assign total_next  = sum_next_q;
	assign total_prev  = sum_prev_q;

endmodule

`default_nettype wire

>>> rtl/finite_difference_extrapolator_top.sv
// ----------------------------------------------------------------------------
// finite_difference_extrapolator_top
// Polynomial extrapolation by repeated differences over one sample sequence.
//
//   channel | handshake            | word
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | sample, last
//   out     | out_valid / out_ready| next_value, prev_value, zero_depth,
//           |                      | no_zero_row, total_next, total_prev
//
// A sample without last is accepted while idle. On last, each row of L
// elements is walked with one read per element from the row memory, then a
// drain state and an evaluate state; the result is then posted. Reset clears
// the sample count, totals and the output valid; the row memory is not
// cleared. A stalled output does not block input until the next result is
// ready to post.
// ----------------------------------------------------------------------------
`default_nettype none

module finite_difference_extrapolator_top #(
	parameter int unsigned MAX_LEN = fde_pkg::MAX_LEN
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [fde_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                last,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [fde_pkg::DATA_W-1:0]        next_value,
	output logic signed [fde_pkg::DATA_W-1:0]        prev_value,
	output logic        [fde_pkg::DEPTH_W-1:0]       zero_depth,
	output logic                                     no_zero_row,
	output logic signed [fde_pkg::DATA_W-1:0]        total_next,
	output logic signed [fde_pkg::DATA_W-1:0]        total_prev
);

	fde_pkg::fde_cmd_t cmd;
	fde_pkg::fde_sts_t sts;

	fde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.last     (last),
		.sts      (sts),
		.cmd      (cmd)
	);

	fde_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.next_value  (next_value),
		.prev_value  (prev_value),
		.zero_depth  (zero_depth),
		.no_zero_row (no_zero_row),
		.total_next  (total_next),
		.total_prev  (total_prev)
	);

endmodule

`default_nettype wire

>>> rtl/fde_chk.sv
// ----------------------------------------------------------------------------
// fde_chk
// Port-level checks for the finite-difference extrapolator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic signed [fde_pkg::SAMPLE_W-1:0] sample,
	input wire logic                                last,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [fde_pkg::DATA_W-1:0]   next_value,
	input wire logic signed [fde_pkg::DATA_W-1:0]   prev_value,
	input wire logic        [fde_pkg::DEPTH_W-1:0]  zero_depth,
	input wire logic                                no_zero_row,
	input wire logic signed [fde_pkg::DATA_W-1:0]   total_next,
	input wire logic signed [fde_pkg::DATA_W-1:0]   total_prev
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_value)
			&& $stable(prev_value) && $stable(total_next) && $stable(total_prev))
		else $error("output word changed while stalled");

	// no zero row reports zero extrapolations and depth
	a_nzr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_zero_row |-> next_value == '0 && prev_value == '0
			&& zero_depth == '0)
		else $error("no_zero_row word carries nonzero fields");

	// a closing word starts the walk, input blocked next cycle
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input ready right after closing word");

	// totals only move when a new word is posted
	a_total_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_next) || !$stable(total_prev)
			|-> out_valid && $past(!out_valid || out_ready))
		else $error("totals changed without a new word");

endmodule

bind finite_difference_extrapolator_top fde_chk u_fde_chk (.*);

`default_nettype wire
